[src/apqm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package apqm_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned OccW  = 7;

	localparam logic       CMD_INSERT = 1'b0;
	localparam logic       CMD_DELETE = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic rd;
		logic cmp;
		logic ptr_from_best;
		logic shift_wr;
		logic ins_fin;
		logic del_fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic rdv;
		logic last_rd;
		logic more;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[src/apqm_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface apqm_req_if;
	import apqm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    command;
	logic signed [WordW-1:0] item_value;
	logic signed [WordW-1:0] item_priority;

	modport source (output valid, command, item_value, item_priority, input ready);
	modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface
`default_nettype wire

[src/apqm_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface apqm_rsp_if;
	import apqm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [WordW-1:0] removed_value;
	logic signed [WordW-1:0] removed_priority;
	logic [OccW-1:0]         occupancy;

	modport source (output valid, status, removed_value, removed_priority, occupancy,
		input ready);
	modport sink   (input valid, status, removed_value, removed_priority, occupancy,
		output ready);
endinterface
`default_nettype wire

[src/array_priority_queue_min_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Bounded min-priority queue of value/priority pairs held in arrival order in a
// single-port-read RAM of DEPTH entries. An insert request appends the pair (or
// reports overflow when full). A delete request scans every held entry, one RAM
// read per cycle, for the smallest priority (larger value wins a tie, then the
// earliest entry), then moves the later entries down one slot, again one read
// and one write per cycle. Delete on an empty queue reports underflow. Every
// result carries the number of entries held afterward. The result sits in an
// output register until taken; the next request is accepted once the current
// one has been handed to that register.
module array_priority_queue_min_unit
	import apqm_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input wire logic   clk,
	input wire logic   arst_n,
	apqm_req_if.sink   req,
	apqm_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	apqm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_command(req.command),
		.in_ready  (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	apqm_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_value     (req.item_value),
		.in_priority  (req.item_priority),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_status   (rsp.status),
		.out_value    (rsp.removed_value),
		.out_priority (rsp.removed_priority),
		.out_occupancy(rsp.occupancy)
	);

endmodule
`default_nettype wire

[src/apqm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module apqm_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[src/apqm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module apqm_ctrl
	import apqm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_command,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		IDLE,
		INS,
		SCAN,
		SCAN_END,
		SHIFT,
		FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE:     cmd.load_in = in_valid;
			INS:      cmd.ins_fin = sts.out_free;
			SCAN: begin
				cmd.rd  = 1'b1;
				cmd.cmp = 1'b1;
			end
			SCAN_END: begin
				cmd.cmp           = 1'b1;
				cmd.ptr_from_best = 1'b1;
			end
			SHIFT: begin
				cmd.rd       = sts.more;
				cmd.shift_wr = 1'b1;
			end
			FIN:      cmd.del_fin = sts.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						if (in_command == CMD_INSERT) begin
							state_q <= INS;
						end else if (sts.empty) begin
							state_q <= FIN;
						end else begin
							state_q <= SCAN;
						end
					end
				end
				INS: begin
					if (sts.out_free) begin
						state_q <= IDLE;
					end
				end
				SCAN: begin
					if (sts.last_rd) begin
						state_q <= SCAN_END;
					end
				end
				SCAN_END: state_q <= SHIFT;
				SHIFT: begin
					if (!sts.more && !sts.rdv) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					if (sts.out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/apqm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module apqm_dp
	import apqm_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	output sts_t                         sts,
	input  wire logic signed [WordW-1:0] in_value,
	input  wire logic signed [WordW-1:0] in_priority,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [1:0]                   out_status,
	output logic signed [WordW-1:0]      out_value,
	output logic signed [WordW-1:0]      out_priority,
	output logic [OccW-1:0]              out_occupancy
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic signed [WordW-1:0] val_q, pri_q;
	logic [CW-1:0]           count_q, ptr_q;
	logic                    rdv_q;
	logic [AW-1:0]           ra_q;
	logic [AW-1:0]           best_idx_q, best_idx_d;
	logic signed [WordW-1:0] best_val_q, best_pri_q;
	logic                    full;

	logic                    we;
	logic [AW-1:0]           waddr;
	logic [2*WordW-1:0]      wdata, rdata;
	logic signed [WordW-1:0] rd_val, rd_pri;
	logic                    better, take;

	apqm_ram #(
		.WIDTH(2 * WordW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	assign full   = (count_q == CW'(DEPTH));
	assign rd_val = rdata[2*WordW-1:WordW];
	assign rd_pri = rdata[WordW-1:0];

	// smaller priority first, larger value on equal priority, earliest on full tie
	assign better = (ra_q == '0) || (rd_pri < best_pri_q)
		|| ((rd_pri == best_pri_q) && (rd_val > best_val_q));
	assign take       = cmd.cmp && rdv_q && better;
	assign best_idx_d = take ? ra_q : best_idx_q;

	always_comb begin
		we    = 1'b0;
		waddr = ra_q - AW'(1);
		wdata = rdata;
		if (cmd.ins_fin && !full) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = {val_q, pri_q};
		end else if (cmd.shift_wr && rdv_q) begin
			we = 1'b1;
		end
	end

	assign sts.empty    = (count_q == '0);
	assign sts.rdv      = rdv_q;
	assign sts.last_rd  = (CW'(ptr_q + CW'(1)) == count_q);
	assign sts.more     = (ptr_q < count_q);
	assign sts.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			val_q <= in_value;
			pri_q <= in_priority;
		end
		if (cmd.rd) begin
			ra_q <= ptr_q[AW-1:0];
		end
		if (take) begin
			best_val_q <= rd_val;
			best_pri_q <= rd_pri;
		end
		best_idx_q <= best_idx_d;
		if (cmd.ins_fin) begin
			out_status    <= full ? STATUS_OVERFLOW : STATUS_OK;
			out_value     <= '0;
			out_priority  <= '0;
			out_occupancy <= full ? OccW'(count_q) : OccW'(count_q + CW'(1));
		end else if (cmd.del_fin) begin
			if (sts.empty) begin
				out_status    <= STATUS_UNDERFLOW;
				out_value     <= '0;
				out_priority  <= '0;
				out_occupancy <= '0;
			end else begin
				out_status    <= STATUS_OK;
				out_value     <= best_val_q;
				out_priority  <= best_pri_q;
				out_occupancy <= OccW'(count_q - CW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ptr_q     <= '0;
			rdv_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rdv_q <= cmd.rd;
			if (cmd.load_in) begin
				ptr_q <= '0;
			end else if (cmd.ptr_from_best) begin
				ptr_q <= CW'(best_idx_d) + CW'(1);
			end else if (cmd.rd) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.ins_fin && !full) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.del_fin && !sts.empty) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.ins_fin || cmd.del_fin) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
